// ===== design/seven_segment_scan_serializer_top_macros.svh =====
// Assertion macros for the seven-segment scan serializer sequencer.
`ifndef SEVEN_SEGMENT_SCAN_SERIALIZER_TOP_MACROS_SVH
`define SEVEN_SEGMENT_SCAN_SERIALIZER_TOP_MACROS_SVH

// Same-cycle implication, checked on clk and disabled in reset.
`define SSS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on clk and disabled in reset.
`define SSS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/sss_pkg.sv =====
// Package with codes, types and tables of the seven-segment scan serializer.
`timescale 1ns / 1ps
package sss_pkg;

  localparam logic [1:0] OP_TICK   = 2'd0;
  localparam logic [1:0] OP_WRITE  = 2'd1;
  localparam logic [1:0] OP_COMMIT = 2'd2;

  localparam logic [1:0] PIN_DATA  = 2'd0;
  localparam logic [1:0] PIN_CLOCK = 2'd1;
  localparam logic [1:0] PIN_LATCH = 2'd2;

  localparam logic [1:0] CFG_DIGIT_COUNT    = 2'd0;
  localparam logic [1:0] CFG_DEVICE_TYPE    = 2'd1;
  localparam logic [1:0] CFG_COMMON_CATHODE = 2'd2;
  localparam logic [1:0] CFG_REVERSED       = 2'd3;

  localparam logic [4:0] BITS_SHIFT_REG = 5'd16;
  localparam logic [4:0] BITS_DRIVER    = 5'd18;

  typedef struct packed {
    logic [2:0] len;
    logic       device_type;
    logic       common_cathode;
    logic       reversed;
  } sss_cfg_t;

  typedef struct packed {
    logic       wr;
    logic       commit;
    logic [1:0] slot;
    logic [7:0] data;
  } sss_store_req_t;

  function automatic logic [7:0] select_code(input logic [1:0] idx);
    logic [7:0] code;
    case (idx)
      2'd0: code = 8'h7f;
      2'd1: code = 8'hbf;
      2'd2: code = 8'hdf;
      2'd3: code = 8'hef;
      default: code = 8'h7f;
    endcase
    return code;
  endfunction

endpackage

// ===== design/sss_in_if.sv =====
// Input channel interface carrying operation words.
`timescale 1ns / 1ps
interface sss_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] operation;
  logic [1:0] position;
  logic [7:0] segments;

  modport source (output valid, output operation, output position, output segments,
                  input ready);
  modport sink (input valid, input operation, input position, input segments,
                output ready);
endinterface

// ===== design/sss_out_if.sv =====
// Output channel interface carrying pin event words.
`timescale 1ns / 1ps
interface sss_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] pin;
  logic       level;
  logic       last;

  modport source (output valid, output pin, output level, output last, input ready);
  modport sink (input valid, input pin, input level, input last, output ready);
endinterface

// ===== design/sss_digit_store.sv =====
// Back and front digit buffers with positional write, commit copy and read.
`timescale 1ns / 1ps
module sss_digit_store
  import sss_pkg::*;
#(
  parameter int MAX_DIGITS = 4
) (
  input  logic           clk,
  input  logic           rst,
  input  sss_store_req_t store_req,
  input  logic [1:0]     rd_idx,
  output logic [7:0]     rd_data
);

  localparam int AW = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;

  logic [7:0] back_digits  [MAX_DIGITS];
  logic [7:0] front_digits [MAX_DIGITS];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_DIGITS; i++) begin
        back_digits[i]  <= 8'h00;
        front_digits[i] <= 8'h00;
      end
    end else begin
      if (store_req.wr) begin
        back_digits[store_req.slot[AW-1:0]] <= store_req.data;
      end
      if (store_req.commit) begin
        for (int i = 0; i < MAX_DIGITS; i++) begin
          front_digits[i] <= back_digits[i];
        end
      end
    end
  end

  assign rd_data = front_digits[rd_idx[AW-1:0]];

endmodule

// ===== design/sss_sequencer.sv =====
// Operation decoder and bit-serial pin event sequencer with output register.
`timescale 1ns / 1ps
`include "seven_segment_scan_serializer_top_macros.svh"
module sss_sequencer
  import sss_pkg::*;
(
  input  logic           clk,
  input  logic           rst,
  sss_in_if.sink         in_ch,
  sss_out_if.source      out_ch,
  input  sss_cfg_t       cfg,
  output sss_store_req_t store_req,
  output logic [1:0]     rd_idx,
  input  logic [7:0]     rd_data
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_HEAD = 4'b0010,
    ST_BITS = 4'b0100,
    ST_TAIL = 4'b1000
  } state_t;

  state_t      state, state_next;
  logic [23:0] shreg, shreg_next;
  logic [4:0]  bitcnt, bitcnt_next;
  logic [1:0]  phase, phase_next;
  logic [2:0]  tailcnt, tailcnt_next;
  logic [2:0]  scan_index;
  logic        out_valid;
  logic [1:0]  out_pin;
  logic        out_level;
  logic        out_last;

  logic        acc;
  logic        tick;
  logic        step;
  logic [2:0]  idx_eff;
  logic [2:0]  pos_ext;
  logic [2:0]  slot_full;
  logic [7:0]  sel_byte;
  logic [7:0]  drv_code;
  logic [1:0]  ev_pin;
  logic        ev_level;
  logic        ev_last;

  assign in_ch.ready = (state == ST_IDLE);
  assign acc  = in_ch.valid && in_ch.ready;
  assign tick = acc && (in_ch.operation == OP_TICK);
  assign step = (state != ST_IDLE) && (!out_valid || out_ch.ready);

  assign idx_eff = (scan_index >= cfg.len) ? 3'd0 : scan_index;
  assign rd_idx  = idx_eff[1:0];

  assign pos_ext   = {1'b0, in_ch.position};
  assign slot_full = cfg.reversed ? (cfg.len - 3'd1 - pos_ext) : pos_ext;

  always_comb begin
    store_req.wr     = acc && (in_ch.operation == OP_WRITE) && (pos_ext < cfg.len);
    store_req.commit = acc && (in_ch.operation == OP_COMMIT);
    store_req.slot   = slot_full[1:0];
    store_req.data   = in_ch.segments;
  end

  assign sel_byte = 8'h01 << idx_eff[1:0];
  assign drv_code = select_code(idx_eff[1:0]);

  always_comb begin
    state_next   = state;
    shreg_next   = shreg;
    bitcnt_next  = bitcnt;
    phase_next   = phase;
    tailcnt_next = tailcnt;
    ev_pin       = PIN_DATA;
    ev_level     = 1'b0;
    ev_last      = 1'b0;
    case (state)
      ST_IDLE: begin
        if (tick) begin
          phase_next   = 2'd0;
          tailcnt_next = 3'd0;
          if (cfg.device_type) begin
            shreg_next  = {drv_code[7:4], 6'b0, rd_data, 6'b0};
            bitcnt_next = BITS_DRIVER;
            state_next  = ST_BITS;
          end else begin
            if (cfg.common_cathode) begin
              shreg_next = {sel_byte, ~rd_data, 8'h00};
            end else begin
              shreg_next = {~sel_byte, rd_data, 8'h00};
            end
            bitcnt_next = BITS_SHIFT_REG;
            state_next  = ST_HEAD;
          end
        end
      end
      ST_HEAD: begin
        ev_pin   = PIN_LATCH;
        ev_level = 1'b0;
        if (step) begin
          state_next = ST_BITS;
        end
      end
      ST_BITS: begin
        case (phase)
          2'd0: begin
            ev_pin   = PIN_DATA;
            ev_level = shreg[23];
          end
          2'd1: begin
            ev_pin   = PIN_CLOCK;
            ev_level = 1'b1;
          end
          default: begin
            ev_pin   = PIN_CLOCK;
            ev_level = 1'b0;
          end
        endcase
        if (step) begin
          if (phase == 2'd2) begin
            phase_next  = 2'd0;
            shreg_next  = {shreg[22:0], 1'b0};
            bitcnt_next = bitcnt - 5'd1;
            if (bitcnt == 5'd1) begin
              state_next = ST_TAIL;
            end
          end else begin
            phase_next = phase + 2'd1;
          end
        end
      end
      ST_TAIL: begin
        if (!cfg.device_type) begin
          ev_pin   = PIN_LATCH;
          ev_level = 1'b1;
          ev_last  = 1'b1;
        end else begin
          case (tailcnt)
            3'd0: begin
              ev_pin   = PIN_DATA;
              ev_level = 1'b0;
            end
            3'd1: begin
              ev_pin   = PIN_DATA;
              ev_level = 1'b1;
            end
            3'd2: begin
              ev_pin   = PIN_CLOCK;
              ev_level = 1'b0;
            end
            3'd3: begin
              ev_pin   = PIN_DATA;
              ev_level = 1'b0;
            end
            default: begin
              ev_pin   = PIN_DATA;
              ev_level = 1'b1;
              ev_last  = 1'b1;
            end
          endcase
        end
        if (step) begin
          tailcnt_next = tailcnt + 3'd1;
          if (ev_last) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      scan_index <= 3'd0;
      out_valid  <= 1'b0;
      bitcnt     <= 5'd0;
      phase      <= 2'd0;
      tailcnt    <= 3'd0;
    end else begin
      state   <= state_next;
      bitcnt  <= bitcnt_next;
      phase   <= phase_next;
      tailcnt <= tailcnt_next;
      if (tick) begin
        scan_index <= idx_eff + 3'd1;
      end
      if (step) begin
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    shreg <= shreg_next;
    if (step) begin
      out_pin   <= ev_pin;
      out_level <= ev_level;
      out_last  <= ev_last;
    end
  end

  assign out_ch.valid = out_valid;
  assign out_ch.pin   = out_pin;
  assign out_ch.level = out_level;
  assign out_ch.last  = out_last;

  `SSS_ASSERT_NEXT(a_tick_busy, tick, (state != ST_IDLE) && !in_ch.ready, "tick did not start")
  `SSS_ASSERT_NEXT(a_tick_bits, tick,
    bitcnt == (cfg.device_type ? BITS_DRIVER : BITS_SHIFT_REG), "wrong bit count")
  `SSS_ASSERT_NEXT(a_last_ends, step && ev_last,
    (state == ST_IDLE) && out_valid && out_last, "last word did not end the tick")
  `SSS_ASSERT_NEXT(a_scan_range, tick,
    (scan_index != 3'd0) && (scan_index <= cfg.len), "scan index out of range")

endmodule

// ===== design/seven_segment_scan_serializer_top.sv =====
// Top level of the seven-segment scan serializer with configuration registers.
//
//   channel  direction  word contents
//   in_ch    sink       operation, position, segments
//   out_ch   source     pin, level, last
//   cfg      write      cfg_we, cfg_index, cfg_data
//
// A write or commit word is accepted while the sequencer is idle. A tick word is
// accepted while idle and then produces 50 (shift-register mode) or 59 (driver mode)
// output words, one per cycle while the sink is ready; input is held off until the
// last one is registered. The counts follow from the head, bit and tail states.
// Synchronous reset clears buffers, scan index and state; digit count resets to 4.
`timescale 1ns / 1ps
module seven_segment_scan_serializer_top
  import sss_pkg::*;
#(
  parameter int MAX_DIGITS = 4
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [2:0] cfg_data,
  sss_in_if.sink     in_ch,
  sss_out_if.source  out_ch
);

  localparam logic [2:0] MaxLen = 3'(MAX_DIGITS);

  logic [2:0]     digit_count;
  logic           device_type;
  logic           common_cathode;
  logic           reversed;
  sss_cfg_t       cfg;
  sss_store_req_t store_req;
  logic [1:0]     rd_idx;
  logic [7:0]     rd_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      digit_count    <= 3'd4;
      device_type    <= 1'b0;
      common_cathode <= 1'b0;
      reversed       <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_DIGIT_COUNT:    digit_count    <= cfg_data;
        CFG_DEVICE_TYPE:    device_type    <= cfg_data[0];
        CFG_COMMON_CATHODE: common_cathode <= cfg_data[0];
        CFG_REVERSED:       reversed       <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (digit_count == 3'd0) begin
      cfg.len = 3'd1;
    end else if (digit_count > MaxLen) begin
      cfg.len = MaxLen;
    end else begin
      cfg.len = digit_count;
    end
    cfg.device_type    = device_type;
    cfg.common_cathode = common_cathode;
    cfg.reversed       = reversed;
  end

  sss_digit_store #(
    .MAX_DIGITS(MAX_DIGITS)
  ) u_store (
    .clk      (clk),
    .rst      (rst),
    .store_req(store_req),
    .rd_idx   (rd_idx),
    .rd_data  (rd_data)
  );

  sss_sequencer u_seq (
    .clk      (clk),
    .rst      (rst),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg      (cfg),
    .store_req(store_req),
    .rd_idx   (rd_idx),
    .rd_data  (rd_data)
  );

endmodule
